// ----- rtl/aad_pkg.sv -----
`default_nettype none

package aad_pkg;

	// default widths of the coordinate inputs and the angle fraction
	localparam int COORD_BITS_DEF      = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 7;

	// fixed output width
	localparam int ANGLE_W = 16;

	// cordic datapath
	localparam int CORDIC_STEPS = 24;
	localparam int ACC_W        = 64;          // x / y datapath width
	localparam int ACC_SCALE    = 56;          // operands scaled to 2^(ACC_SCALE - COORD_BITS)
	localparam int ACC_FRAC     = 20;          // angle accumulator unit is 2^-20 degree
	localparam int Z_W          = 30;          // signed angle accumulator width

	localparam logic signed [Z_W-1:0] DEG90_ACC  = Z_W'(94371840);
	localparam logic signed [Z_W-1:0] DEG180_ACC = Z_W'(188743680);

	// reference mode codes; the unused code behaves as none
	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_VERT  = 2'd1;
	localparam logic [1:0] MODE_HORIZ = 2'd2;

	// side information that travels with each item through the pipeline
	typedef struct packed {
		logic           neg;
		logic           degen;
		logic           spec;
		logic [Z_W-1:0] spec_mag;
	} tag_t;

	// atan(2^-i) in units of 2^-20 degree
	function automatic logic signed [Z_W-1:0] atan_step(input int unsigned idx);
		logic signed [Z_W-1:0] v;
		case (idx)
			0:  v = Z_W'(47185920);
			1:  v = Z_W'(27855475);
			2:  v = Z_W'(14718068);
			3:  v = Z_W'(7471121);
			4:  v = Z_W'(3750058);
			5:  v = Z_W'(1876857);
			6:  v = Z_W'(938658);
			7:  v = Z_W'(469357);
			8:  v = Z_W'(234682);
			9:  v = Z_W'(117342);
			10: v = Z_W'(58671);
			11: v = Z_W'(29335);
			12: v = Z_W'(14668);
			13: v = Z_W'(7334);
			14: v = Z_W'(3667);
			15: v = Z_W'(1833);
			16: v = Z_W'(917);
			17: v = Z_W'(458);
			18: v = Z_W'(229);
			19: v = Z_W'(115);
			20: v = Z_W'(57);
			21: v = Z_W'(29);
			22: v = Z_W'(14);
			23: v = Z_W'(7);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/aim_angle_degrees.sv -----
// channel   signals                                                  transfer when
// -------   ------------------------------------------------------   -----------------------
// command   start, busy, source_x/y, target_x/y, reference_mode      start high, busy low
// result    done, angle, degenerate                                  done high (one cycle)
//
// one command is taken every clock; busy stays low since nothing can stall
// each result passes through the registered stages difference, pre-rotation,
// 24 cordic stages (one iteration per stage), clamp, then rounding and sign
// results leave in command order and the receiver cannot hold them off
// arst_n clears the valid bits only; datapath registers carry no reset

`default_nettype none

module aim_angle_degrees #(
	parameter int COORD_BITS      = aad_pkg::COORD_BITS_DEF,
	parameter int ANGLE_FRAC_BITS = aad_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     start,
	output logic                                    busy,
	input  wire  signed [COORD_BITS-1:0]            source_x,
	input  wire  signed [COORD_BITS-1:0]            source_y,
	input  wire  signed [COORD_BITS-1:0]            target_x,
	input  wire  signed [COORD_BITS-1:0]            target_y,
	input  wire         [1:0]                       reference_mode,
	output logic                                    done,
	output logic signed [aad_pkg::ANGLE_W-1:0]      angle,
	output logic                                    degenerate
);

	localparam int D_W   = COORD_BITS + 1;                 // width of a coordinate difference
	localparam int SCALE = aad_pkg::ACC_SCALE - COORD_BITS;
	localparam int ACC_W = aad_pkg::ACC_W;
	localparam int Z_W   = aad_pkg::Z_W;
	localparam int STEPS = aad_pkg::CORDIC_STEPS;
	localparam int RSH   = aad_pkg::ACC_FRAC - ANGLE_FRAC_BITS;   // rounding shift

	// never stalls
	assign busy = 1'b0;

	// ---------------------------------------------------------------
	// stage 1: coordinate differences
	// ---------------------------------------------------------------
	logic                  vld_s1;
	logic signed [D_W-1:0] dx_s1, dy_s1;
	logic [1:0]            mode_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1   <= D_W'(target_x) - D_W'(source_x);
		dy_s1   <= D_W'(target_y) - D_W'(source_y);
		mode_s1 <= reference_mode;
	end

	// ---------------------------------------------------------------
	// stage 2: pick reference and perpendicular axes, pre-rotate into
	// the right half plane, flag the exact cases
	// ---------------------------------------------------------------
	logic signed [D_W-1:0]   ref_c, perp_c, perp_abs;
	logic signed [D_W-1:0]   ref_neg;
	logic                    neg_c, degen_c, spec_c;
	logic [Z_W-1:0]          spec_mag_c;
	logic signed [ACC_W-1:0] ref_ext, negref_ext, perp_ext;
	logic signed [ACC_W-1:0] x0_c, y0_c;
	logic signed [Z_W-1:0]   z0_c;

	always_comb begin
		degen_c = (dx_s1 == '0) && (dy_s1 == '0);
		if (mode_s1 == aad_pkg::MODE_VERT) begin
			ref_c  = dy_s1;
			perp_c = dx_s1;
			neg_c  = !dx_s1[D_W-1];
		end else begin
			ref_c  = dx_s1;
			perp_c = dy_s1;
			neg_c  = (mode_s1 == aad_pkg::MODE_HORIZ) && (dy_s1[D_W-1] || (dy_s1 == '0));
		end
		// differences never reach the most negative code, so negation is safe
		perp_abs = perp_c[D_W-1] ? -perp_c : perp_c;
		ref_neg  = -ref_c;

		// on the reference axis or exactly perpendicular to it
		spec_c     = 1'b0;
		spec_mag_c = '0;
		if (perp_abs == '0) begin
			spec_c     = 1'b1;
			spec_mag_c = ref_c[D_W-1] ? aad_pkg::DEG180_ACC : '0;
		end else if (ref_c == '0) begin
			spec_c     = 1'b1;
			spec_mag_c = aad_pkg::DEG90_ACC;
		end
		if (degen_c) begin
			neg_c = 1'b0;
		end

		ref_ext    = {{(ACC_W-D_W){ref_c[D_W-1]}}, ref_c} <<< SCALE;
		negref_ext = {{(ACC_W-D_W){ref_neg[D_W-1]}}, ref_neg} <<< SCALE;
		perp_ext   = {{(ACC_W-D_W){perp_abs[D_W-1]}}, perp_abs} <<< SCALE;

		// left half plane: rotate by -90 degrees and start the angle at 90
		if (ref_c[D_W-1]) begin
			x0_c = perp_ext;
			y0_c = negref_ext;
			z0_c = aad_pkg::DEG90_ACC;
		end else begin
			x0_c = ref_ext;
			y0_c = perp_ext;
			z0_c = '0;
		end
	end

	// cordic pipeline; entry 0 is the pre-rotation register, entry k holds
	// the vector after k iterations
	logic                    vld_s [0:STEPS];
	logic signed [ACC_W-1:0] cx_s [0:STEPS];
	logic signed [ACC_W-1:0] cy_s [0:STEPS];
	logic signed [Z_W-1:0]   cz_s [0:STEPS];
	aad_pkg::tag_t           tag_s [0:STEPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		cx_s[0]           <= x0_c;
		cy_s[0]           <= y0_c;
		cz_s[0]           <= z0_c;
		tag_s[0].neg      <= neg_c;
		tag_s[0].degen    <= degen_c;
		tag_s[0].spec     <= spec_c;
		tag_s[0].spec_mag <= spec_mag_c;
	end

	// ---------------------------------------------------------------
	// cordic vectoring: one iteration per stage, driving y toward zero
	// ---------------------------------------------------------------
	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		logic                    up;
		logic signed [ACC_W-1:0] xs, ys;

		assign up = !cy_s[i][ACC_W-1] && (cy_s[i] != '0);
		assign xs = cx_s[i] >>> i;
		assign ys = cy_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (up) begin
				cx_s[i+1] <= cx_s[i] + ys;
				cy_s[i+1] <= cy_s[i] - xs;
				cz_s[i+1] <= cz_s[i] + aad_pkg::atan_step(i);
			end else begin
				cx_s[i+1] <= cx_s[i] - ys;
				cy_s[i+1] <= cy_s[i] + xs;
				cz_s[i+1] <= cz_s[i] - aad_pkg::atan_step(i);
			end
			tag_s[i+1] <= tag_s[i];
		end
	end

	// ---------------------------------------------------------------
	// clamp stage: limit to [0, 180] degrees, substitute exact cases
	// ---------------------------------------------------------------
	logic                  vld_sc;
	logic                  neg_sc, degen_sc;
	logic [Z_W-1:0]        mag_sc;
	logic [Z_W-1:0]        mag_c;
	logic signed [Z_W-1:0] zf;

	assign zf = cz_s[STEPS];

	always_comb begin
		if (zf[Z_W-1]) begin
			mag_c = '0;
		end else if (zf > aad_pkg::DEG180_ACC) begin
			mag_c = aad_pkg::DEG180_ACC;
		end else begin
			mag_c = zf;
		end
		if (tag_s[STEPS].degen) begin
			mag_c = '0;
		end else if (tag_s[STEPS].spec) begin
			mag_c = tag_s[STEPS].spec_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sc <= 1'b0;
		end else begin
			vld_sc <= vld_s[STEPS];
		end
	end

	always_ff @(posedge clk) begin
		mag_sc   <= mag_c;
		neg_sc   <= tag_s[STEPS].neg;
		degen_sc <= tag_s[STEPS].degen;
	end

	// ---------------------------------------------------------------
	// output stage: round half up to the output fraction, apply sign
	// ---------------------------------------------------------------
	logic [Z_W-1:0]      rsum_c, rnd_c;
	logic signed [Z_W:0] sres_c;

	always_comb begin
		rsum_c = mag_sc + (Z_W'(1) << (RSH - 1));
		rnd_c  = rsum_c >> RSH;
		sres_c = neg_sc ? -$signed({1'b0, rnd_c}) : $signed({1'b0, rnd_c});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_sc;
		end
	end

	always_ff @(posedge clk) begin
		angle      <= sres_c[aad_pkg::ANGLE_W-1:0];
		degenerate <= degen_sc;
	end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

	localparam int COORD_W = aad_pkg::COORD_BITS_DEF;
	localparam int ANG_W   = aad_pkg::ANGLE_W;
	localparam int STEPS   = aad_pkg::CORDIC_STEPS;

	// unused mode code, expected to act like none
	localparam logic [1:0] MODE_SPARE = 2'd3;

	// fixed-point constants of the angle unit (2^-20 degree)
	localparam int     SCALE_SH   = aad_pkg::ACC_SCALE - COORD_W;
	localparam int     FRAC_SH    = aad_pkg::ACC_FRAC - aad_pkg::ANGLE_FRAC_BITS_DEF;
	localparam longint DEG90_Q20  = 64'sd94371840;
	localparam longint DEG180_Q20 = 64'sd188743680;
	localparam longint ROUND_HALF = 64'sd1 <<< (FRAC_SH - 1);
	localparam longint ATAN_Q20 [STEPS] = '{
		47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658, 469357,
		234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
		917, 458, 229, 115, 57, 29, 14, 7
	};

	// pipeline drain plus margin
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_CMDS  = 1400;
	localparam int MAX_PRINTS   = 40;

	typedef struct {
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] tx;
		logic signed [COORD_W-1:0] ty;
		logic [1:0]                mode;
		int unsigned               gap;
	} aim_cmd_t;

	typedef struct {
		logic signed [ANG_W-1:0] angle;
		logic                    degen;
	} aim_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [COORD_W-1:0] source_x = '0;
	logic signed [COORD_W-1:0] source_y = '0;
	logic signed [COORD_W-1:0] target_x = '0;
	logic signed [COORD_W-1:0] target_y = '0;
	logic [1:0] reference_mode = aad_pkg::MODE_NONE;
	logic done;
	logic signed [ANG_W-1:0] angle;
	logic degenerate;

	aim_cmd_t    cmd_pending_q [$];
	aim_result_t angle_expect_q [$];

	int unsigned idle_left = 0;
	int          err_count = 0;
	int          n_issued = 0;
	int          n_checked = 0;
	int          n_degen = 0;
	int          mode_seen [4] = '{0, 0, 0, 0};
	int          cycle_count = 0;
	bit          burst_on = 1'b0;

	aim_angle_degrees uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.source_x       (source_x),
		.source_y       (source_y),
		.target_x       (target_x),
		.target_y       (target_y),
		.reference_mode (reference_mode),
		.done           (done),
		.angle          (angle),
		.degenerate     (degenerate)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// hard stop in case results never come
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending",
				cycle_count, angle_expect_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (err_count < MAX_PRINTS)
			$display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		err_count++;
	endtask

	// unsigned angle of (ref_c, perp) with perp >= 0, 24-step cordic vectoring in 2^-20 degree
	function automatic longint cordic_magnitude(input longint ref_c, input longint perp);
		longint x, y, z, xs, ys, base;
		int i;
		if (perp == 0)
			return (ref_c > 0) ? 64'sd0 : DEG180_Q20;
		if (ref_c == 0)
			return DEG90_Q20;
		// pre-rotate the left half-plane by 90 degrees
		if (ref_c < 0) begin
			base = DEG90_Q20;
			x = perp <<< SCALE_SH;
			y = (-ref_c) <<< SCALE_SH;
		end else begin
			base = 0;
			x = ref_c <<< SCALE_SH;
			y = perp <<< SCALE_SH;
		end
		z = 0;
		for (i = 0; i < STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_Q20[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_Q20[i];
			end
		end
		z = z + base;
		if (z < 0)
			z = 0;
		if (z > DEG180_Q20)
			z = DEG180_Q20;
		return z;
	endfunction

	// signed aim angle in 1/128 degree from the command fields
	function automatic aim_result_t aim_angle_predict(
		input logic signed [COORD_W-1:0] sx,
		input logic signed [COORD_W-1:0] sy,
		input logic signed [COORD_W-1:0] tx,
		input logic signed [COORD_W-1:0] ty,
		input logic [1:0]                mode
	);
		aim_result_t r;
		longint dx, dy, ref_c, perp, mag, rounded;
		logic neg;
		dx = longint'(tx) - longint'(sx);
		dy = longint'(ty) - longint'(sy);
		if (dx == 0 && dy == 0) begin
			r.angle = '0;
			r.degen = 1'b1;
			return r;
		end
		if (mode == aad_pkg::MODE_VERT) begin
			ref_c = dy;
			perp = (dx < 0) ? -dx : dx;
			neg = (dx >= 0);
		end else begin
			// none, horizontal and the spare code all measure from +x
			ref_c = dx;
			perp = (dy < 0) ? -dy : dy;
			neg = (mode == aad_pkg::MODE_HORIZ) && (dy <= 0);
		end
		mag = cordic_magnitude(ref_c, perp);
		rounded = (mag + ROUND_HALF) >>> FRAC_SH;
		if (neg)
			rounded = -rounded;
		r.angle = rounded[ANG_W-1:0];
		r.degen = 1'b0;
		return r;
	endfunction

	// queue one command; the sender gap after it alternates between bursts and random idling
	task automatic queue_cmd(input int sx, input int sy, input int tx, input int ty,
			input logic [1:0] mode);
		aim_cmd_t c;
		if ($urandom_range(0, 39) == 0)
			burst_on = !burst_on;
		c.sx = sx[COORD_W-1:0];
		c.sy = sy[COORD_W-1:0];
		c.tx = tx[COORD_W-1:0];
		c.ty = ty[COORD_W-1:0];
		c.mode = mode;
		c.gap = burst_on ? 0 : $urandom_range(0, 14);
		cmd_pending_q.push_back(c);
	endtask

	function automatic int edge_coord();
		case ($urandom_range(0, 4))
			0: return -32768;
			1: return 32767;
			2: return 0;
			3: return -1;
			default: return 1;
		endcase
	endfunction

	// command driver: one transfer per edge with start high and busy low
	always @(posedge clk or negedge arst_n) begin
		aim_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			idle_left <= 0;
		end else begin
			if (start && !busy) begin
				angle_expect_q.push_back(aim_angle_predict(source_x, source_y,
					target_x, target_y, reference_mode));
				mode_seen[reference_mode]++;
				n_issued++;
			end
			if (start && busy) begin
				// command not taken yet, keep it on the ports
			end else if (idle_left != 0) begin
				start <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (cmd_pending_q.size() != 0) begin
				nxt = cmd_pending_q.pop_front();
				source_x <= nxt.sx;
				source_y <= nxt.sy;
				target_x <= nxt.tx;
				target_y <= nxt.ty;
				reference_mode <= nxt.mode;
				idle_left <= nxt.gap;
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// result monitor: done marks a single-cycle transfer, checked in order
	always @(posedge clk) begin
		aim_result_t want;
		if (arst_n && done) begin
			if (angle_expect_q.size() == 0) begin
				report_mismatch("unexpected result, angle", angle, 0);
			end else begin
				want = angle_expect_q.pop_front();
				if (angle !== want.angle)
					report_mismatch("angle", angle, want.angle);
				if (degenerate !== want.degen)
					report_mismatch("degenerate", degenerate, want.degen);
				n_checked++;
				if (want.degen)
					n_degen++;
			end
		end
	end

	initial begin
		int sx, sy, tx, ty, kind;
		logic [1:0] mode;

		// directed: coincident points
		queue_cmd(0, 0, 0, 0, aad_pkg::MODE_NONE);
		queue_cmd(-32768, -32768, -32768, -32768, aad_pkg::MODE_HORIZ);
		queue_cmd(32767, 32767, 32767, 32767, aad_pkg::MODE_VERT);
		// on the reference axis, both directions, sign rule applied
		queue_cmd(0, 0, 16, 0, aad_pkg::MODE_HORIZ);
		queue_cmd(0, 0, -16, 0, aad_pkg::MODE_HORIZ);
		queue_cmd(0, 0, -16, 0, aad_pkg::MODE_NONE);
		queue_cmd(0, 0, 0, 16, aad_pkg::MODE_VERT);
		queue_cmd(0, 0, 0, -16, aad_pkg::MODE_VERT);
		// perpendicular to the reference axis
		queue_cmd(0, 0, 0, 16, aad_pkg::MODE_HORIZ);
		queue_cmd(0, 0, 0, -16, aad_pkg::MODE_HORIZ);
		queue_cmd(0, 0, 16, 0, aad_pkg::MODE_VERT);
		queue_cmd(0, 0, -16, 0, aad_pkg::MODE_VERT);
		// largest differences in every quadrant
		queue_cmd(-32768, -32768, 32767, 32767, aad_pkg::MODE_NONE);
		queue_cmd(32767, -32768, -32768, 32767, aad_pkg::MODE_HORIZ);
		queue_cmd(32767, 32767, -32768, -32768, aad_pkg::MODE_HORIZ);
		queue_cmd(-32768, 32767, 32767, -32768, aad_pkg::MODE_VERT);
		queue_cmd(32767, 0, -32768, 1, aad_pkg::MODE_HORIZ);
		queue_cmd(0, 0, 32767, -1, aad_pkg::MODE_HORIZ);
		// smallest steps, and the spare mode
		queue_cmd(0, 0, 1, 1, aad_pkg::MODE_NONE);
		queue_cmd(0, 0, 1, -1, MODE_SPARE);
		queue_cmd(0, 0, -1, -1, MODE_SPARE);
		queue_cmd(100, -200, 101, 31800, aad_pkg::MODE_VERT);

		// random part
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			kind = $urandom_range(0, 9);
			sx = int'($urandom_range(0, 65535)) - 32768;
			sy = int'($urandom_range(0, 65535)) - 32768;
			tx = int'($urandom_range(0, 65535)) - 32768;
			ty = int'($urandom_range(0, 65535)) - 32768;
			case (kind)
				5, 6: begin
					// short vectors, wrapped to the coordinate width
					tx = sx + int'($urandom_range(0, 32)) - 16;
					ty = sy + int'($urandom_range(0, 32)) - 16;
				end
				7: begin
					// target on one axis through the source
					if ($urandom_range(0, 1))
						tx = sx;
					else
						ty = sy;
				end
				8: begin
					tx = sx;
					ty = sy;
				end
				9: begin
					sx = edge_coord();
					sy = edge_coord();
					tx = edge_coord();
					ty = edge_coord();
				end
				default: ;
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2: mode = aad_pkg::MODE_NONE;
				3, 4, 5: mode = aad_pkg::MODE_VERT;
				6, 7, 8: mode = aad_pkg::MODE_HORIZ;
				default: mode = MODE_SPARE;
			endcase
			queue_cmd(sx, sy, tx, ty, mode);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every command and every result
		do
			@(negedge clk);
		while (cmd_pending_q.size() != 0 || start || angle_expect_q.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("aim angle run: %0d commands (none %0d, vertical %0d, horizontal %0d, spare %0d)",
			n_issued, mode_seen[aad_pkg::MODE_NONE], mode_seen[aad_pkg::MODE_VERT],
			mode_seen[aad_pkg::MODE_HORIZ], mode_seen[MODE_SPARE]);
		$display("results checked %0d, coincident points %0d, mismatches %0d",
			n_checked, n_degen, err_count);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/aad_pkg.sv
rtl/aim_angle_degrees.sv
tb/tb_top.sv
